// ===== rtl/pdss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_pkg
// Types and constants shared by the priority dispatcher and its queue cells.
// ----------------------------------------------------------------------------
package pdss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] SERVICE_RESET = 16'd5;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] tag;
    logic [3:0]  severity;
    logic [31:0] arrival_time;
  } in_t;

  typedef struct packed {
    logic        dispatched;
    logic [15:0] out_tag;
    logic [3:0]  out_severity;
    logic [31:0] wait_time;
    logic        dropped;
    logic [4:0]  queue_count;
    logic        server_busy;
  } out_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [3:0]  severity;
    logic [31:0] arrival;
  } entry_t;

  // command broadcast to every cell of the queue
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t ent;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/pdss_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdss_cell
// One slot of the sorted queue: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module pdss_cell (
  input  wire logic               clk,
  input  wire pdss_pkg::cell_cmd_t cmd,
  input  wire logic               occupied,
  input  wire logic               prev_keep,
  input  wire pdss_pkg::entry_t   prev_entry,
  input  wire pdss_pkg::entry_t   next_entry,
  output logic                    keep,
  output pdss_pkg::entry_t        entry
);
  import pdss_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // an equal key stays ahead: earlier insertion wins the tie
  assign keep = occupied &&
                ((entry_r.severity > cmd.ent.severity) ||
                 ((entry_r.severity == cmd.ent.severity) &&
                  (entry_r.arrival <= cmd.ent.arrival)));

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (prev_keep) begin
        entry_nxt = cmd.ent;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (cmd.del) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

// ===== rtl/priority_dispatch_single_server.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_dispatch_single_server
// Strict-priority queue in front of one non-preemptive server.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless stalled and returns one result beat for each
// in the next cycle through an output register; in_stall rises only while that
// register is full and out_stall holds it. The queue is a row of QUEUE_DEPTH
// cells kept sorted by severity, then arrival, then insertion: an enqueue
// inserts in place with each cell comparing against the broadcast entry, a
// dispatch takes the head and shifts the row by one. The service time register
// is written through the cfg port at any cycle (cfg_ready is always high).
module priority_dispatch_single_server (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire pdss_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output pdss_pkg::out_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [15:0]     cfg_data
);
  import pdss_pkg::*;

  logic [15:0]      service_r;
  logic [31:0]      cur_r, cur_nxt;
  logic [31:0]      busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_t             out_data_r, res;

  logic             accept, full, free, do_ins, do_del;
  logic [31:0]      count_ext;
  cell_cmd_t        cmd;
  entry_t           new_ent;
  entry_t           cell_entry [QUEUE_DEPTH];
  logic             cell_keep  [QUEUE_DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign free   = (cur_r >= busy_r);
  assign do_ins = accept && (in_data.op == OP_ENQUEUE) && !full;
  assign do_del = accept && (in_data.op == OP_TICK) && free && (count_r != '0);

  assign new_ent.tag      = in_data.tag;
  assign new_ent.severity = in_data.severity;
  assign new_ent.arrival  = in_data.arrival_time;

  assign cmd.ins = do_ins;
  assign cmd.del = do_del;
  assign cmd.ent = new_ent;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t prev_e, next_e;
      logic   prev_k;
      if (gi == 0) begin : g_head
        assign prev_e = new_ent;
        assign prev_k = 1'b1;
      end else begin : g_mid
        assign prev_e = cell_entry[gi-1];
        assign prev_k = cell_keep[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_body
        assign next_e = cell_entry[gi+1];
      end
      pdss_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (CNT_W'(gi) < count_r),
        .prev_keep  (prev_k),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .keep       (cell_keep[gi]),
        .entry      (cell_entry[gi])
      );
    end
  endgenerate

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (accept && (in_data.op == OP_TICK)) begin
      cur_nxt = cur_r + 32'd1;
      if (do_del) begin
        busy_nxt  = cur_r + 32'(service_r);
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign count_ext = 32'(count_nxt);

  always_comb begin
    res              = '0;
    res.dispatched   = do_del;
    if (do_del) begin
      res.out_tag      = cell_entry[0].tag;
      res.out_severity = cell_entry[0].severity;
      res.wait_time    = cur_r - cell_entry[0].arrival;
    end
    res.dropped      = accept && (in_data.op == OP_ENQUEUE) && full;
    res.queue_count  = count_ext[4:0];
    res.server_busy  = (cur_nxt < busy_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_r   <= SERVICE_RESET;
      cur_r       <= '0;
      busy_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        service_r <= cfg_data;
      end
      cur_r   <= cur_nxt;
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
